// ----- rtl/core/psu_pkg.sv -----
// Shared constants and types for the PNG scanline unfilter.
package psu_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_BPP     = 4;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_BPP;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int BIP_W    = $clog2(MAX_BPP);
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 16;
  localparam int BPP_W    = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPP    = 2'd2;

  typedef logic [7:0] sample_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef struct packed {
    sample_t left;
    sample_t up;
    sample_t upleft;
  } nbr_t;

endpackage

// ----- rtl/core/psu_predict.sv -----
// Predictor and reconstruction add for one filtered byte.
module psu_predict (
  input  psu_pkg::filt_t   filt,
  input  psu_pkg::nbr_t    nbr,
  input  psu_pkg::sample_t data_in,
  output psu_pkg::sample_t data_out
);

  logic signed [9:0] a_s, b_s, c_s;
  logic signed [9:0] da, db, dc;
  logic [9:0] pa, pb, pc;
  psu_pkg::sample_t paeth;
  psu_pkg::sample_t pred;
  logic [8:0] avg_sum;

  always_comb begin
    a_s = {2'b00, nbr.left};
    b_s = {2'b00, nbr.up};
    c_s = {2'b00, nbr.upleft};
    da  = b_s - c_s;
    db  = a_s - c_s;
    dc  = a_s + b_s - c_s - c_s;
    pa  = da[9] ? 10'(-da) : 10'(da);
    pb  = db[9] ? 10'(-db) : 10'(db);
    pc  = dc[9] ? 10'(-dc) : 10'(dc);
    priority if (pa <= pb && pa <= pc) begin
      paeth = nbr.left;
    end else if (pb <= pc) begin
      paeth = nbr.up;
    end else begin
      paeth = nbr.upleft;
    end
  end

  assign avg_sum = {1'b0, nbr.left} + {1'b0, nbr.up};

  always_comb begin
    unique case (filt)
      psu_pkg::FILT_NONE:  pred = 8'd0;
      psu_pkg::FILT_SUB:   pred = nbr.left;
      psu_pkg::FILT_UP:    pred = nbr.up;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: pred = paeth;
      default:             pred = 8'd0;
    endcase
  end

  assign data_out = data_in + pred;

endmodule

// ----- rtl/core/png_scanline_unfilter_unit.sv -----
// PNG scanline unfilter: top level with position tracking, line store and output register.
// Takes one stream beat per cycle while the output is not stalled and gives one reconstructed
// byte per data beat. A data beat issues its read of the previous row's byte from the
// single-port-read line store on acceptance; the predictor then forms the byte in the
// compute stage, which, when it moves on, writes it back to the same line store entry and
// loads the output register. Filter-type beats give no output; an unknown filter type gives
// one beat with tuser set and the rest of the frame is dropped until in_tuser marks a new frame.
module png_scanline_unfilter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic                              in_tuser,   // [0] frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] pixel_byte
  output logic                              out_tlast,
  output logic                              out_tuser,  // [0] bad_filter
  input  logic                              cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psu_pkg::CFG_W-1:0]         cfg_wdata
);

  // configuration
  logic [psu_pkg::WIDTH_W-1:0]  width_r;
  logic [psu_pkg::HEIGHT_W-1:0] height_r;
  logic [psu_pkg::BPP_W-1:0]    bpp_r;
  logic [psu_pkg::WIDTH_W-1:0]  w_eff;
  logic [psu_pkg::HEIGHT_W-1:0] h_eff;
  logic [psu_pkg::BPP_W-1:0]    bpp_eff;

  // position state
  logic [psu_pkg::COL_W-1:0]    col_r, col_nxt, cur_col;
  logic [psu_pkg::BIP_W-1:0]    bip_r, bip_nxt, cur_bip;
  logic [psu_pkg::HEIGHT_W-1:0] row_r, row_nxt, cur_row;
  logic [psu_pkg::ADDR_W-1:0]   addr_r, addr_nxt, cur_addr;
  psu_pkg::filt_t               filt_r, filt_nxt, cur_filt;
  logic                         await_r, await_nxt, cur_await;
  logic                         drop_r, drop_nxt, cur_drop;
  logic                         s0_load, s0_err, s0_last;

  // compute stage
  logic                         s1_valid_r;
  logic                         s1_err_r;
  logic                         s1_last_r;
  logic                         s1_has_left_r;
  logic                         s1_has_up_r;
  psu_pkg::filt_t               s1_filt_r;
  psu_pkg::sample_t             s1_data_r;
  logic [psu_pkg::BIP_W-1:0]    s1_slot_r;
  logic [psu_pkg::ADDR_W-1:0]   s1_addr_r;
  psu_pkg::sample_t             rd_data_r;
  psu_pkg::nbr_t                nbr;
  psu_pkg::sample_t             val;

  // output register
  logic                         out_valid_r;
  psu_pkg::sample_t             out_data_r;
  logic                         out_last_r;
  logic                         out_err_r;

  logic in_fire, s1_fire, out_free;

  psu_pkg::sample_t store [psu_pkg::STORE_DEPTH];
  psu_pkg::sample_t left_r [psu_pkg::MAX_BPP];
  psu_pkg::sample_t ul_r [psu_pkg::MAX_BPP];

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= psu_pkg::WIDTH_W'(1);
      height_r <= psu_pkg::HEIGHT_W'(1);
      bpp_r    <= psu_pkg::BPP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        psu_pkg::REG_WIDTH:  width_r  <= cfg_wdata[psu_pkg::WIDTH_W-1:0];
        psu_pkg::REG_HEIGHT: height_r <= cfg_wdata[psu_pkg::HEIGHT_W-1:0];
        psu_pkg::REG_BPP:    bpp_r    <= cfg_wdata[psu_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = psu_pkg::WIDTH_W'(1);
    end else if (width_r > psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH)) begin
      w_eff = psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (bpp_r == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (bpp_r > psu_pkg::BPP_W'(psu_pkg::MAX_BPP)) begin
      bpp_eff = psu_pkg::BPP_W'(psu_pkg::MAX_BPP);
    end else begin
      bpp_eff = bpp_r;
    end
    h_eff = (height_r == '0) ? psu_pkg::HEIGHT_W'(1) : height_r;
  end

  // frame start view of the position, then the step for this beat
  always_comb begin
    cur_col   = in_tuser ? '0 : col_r;
    cur_bip   = in_tuser ? '0 : bip_r;
    cur_row   = in_tuser ? '0 : row_r;
    cur_addr  = in_tuser ? '0 : addr_r;
    cur_filt  = in_tuser ? psu_pkg::FILT_NONE : filt_r;
    cur_await = in_tuser ? 1'b1 : await_r;
    cur_drop  = in_tuser ? 1'b0 : drop_r;

    col_nxt   = cur_col;
    bip_nxt   = cur_bip;
    row_nxt   = cur_row;
    addr_nxt  = cur_addr;
    filt_nxt  = cur_filt;
    await_nxt = cur_await;
    drop_nxt  = cur_drop;
    s0_load   = 1'b0;
    s0_err    = 1'b0;
    s0_last   = 1'b0;

    if (!cur_drop) begin
      if (cur_await) begin
        if (in_tdata > {5'd0, psu_pkg::FILT_PAETH}) begin
          drop_nxt = 1'b1;
          s0_load  = 1'b1;
          s0_err   = 1'b1;
        end else begin
          filt_nxt  = psu_pkg::filt_t'(in_tdata[2:0]);
          await_nxt = 1'b0;
          col_nxt   = '0;
          bip_nxt   = '0;
          addr_nxt  = '0;
        end
      end else begin
        s0_load  = 1'b1;
        addr_nxt = cur_addr + psu_pkg::ADDR_W'(1);
        if (psu_pkg::BPP_W'(cur_bip) + psu_pkg::BPP_W'(1) >= bpp_eff) begin
          bip_nxt = '0;
          if (psu_pkg::WIDTH_W'(cur_col) + psu_pkg::WIDTH_W'(1) >= w_eff) begin
            col_nxt   = '0;
            await_nxt = 1'b1;
            if ({1'b0, cur_row} + 17'd1 >= {1'b0, h_eff}) begin
              s0_last = 1'b1;
              row_nxt = '0;
            end else begin
              row_nxt = cur_row + psu_pkg::HEIGHT_W'(1);
            end
          end else begin
            col_nxt = cur_col + psu_pkg::COL_W'(1);
          end
        end else begin
          bip_nxt = cur_bip + psu_pkg::BIP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      bip_r   <= '0;
      row_r   <= '0;
      addr_r  <= '0;
      filt_r  <= psu_pkg::FILT_NONE;
      await_r <= 1'b1;
      drop_r  <= 1'b0;
    end else if (in_fire) begin
      col_r   <= col_nxt;
      bip_r   <= bip_nxt;
      row_r   <= row_nxt;
      addr_r  <= addr_nxt;
      filt_r  <= filt_nxt;
      await_r <= await_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // line store: read on accept, write back when the byte leaves the compute stage
  always_ff @(posedge clk) begin
    if (in_fire && s0_load) begin
      rd_data_r <= store[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !s1_err_r) begin
      store[s1_addr_r] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= s0_load;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && s0_load) begin
      s1_err_r      <= s0_err;
      s1_last_r     <= s0_last;
      s1_has_left_r <= (cur_col != '0);
      s1_has_up_r   <= (cur_row != '0);
      s1_filt_r     <= cur_filt;
      s1_data_r     <= in_tdata;
      s1_slot_r     <= cur_bip;
      s1_addr_r     <= cur_addr;
    end
  end

  always_comb begin
    nbr.left   = s1_has_left_r ? left_r[s1_slot_r] : 8'd0;
    nbr.up     = s1_has_up_r ? rd_data_r : 8'd0;
    nbr.upleft = (s1_has_left_r && s1_has_up_r) ? ul_r[s1_slot_r] : 8'd0;
  end

  psu_predict u_predict (
    .filt     (s1_filt_r),
    .nbr      (nbr),
    .data_in  (s1_data_r),
    .data_out (val)
  );

  always_ff @(posedge clk) begin
    if (s1_fire && !s1_err_r) begin
      left_r[s1_slot_r] <= val;
      ul_r[s1_slot_r]   <= nbr.up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= s1_err_r ? 8'd0 : val;
      out_last_r <= s1_err_r ? 1'b0 : s1_last_r;
      out_err_r  <= s1_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule
